### src/ledm_pkg.sv
// shared types, constants and glyph tables for the two-digit led matrix frame builder
// used by ledm_digit_split, led_matrix_two_digit_frame_top and the testbench; depends on nothing
package ledm_pkg;

    localparam int ROWS  = 8;
    localparam int ROW_W = $clog2(ROWS);

    // largest reading shown, in tenths
    localparam logic [9:0]  VALUE_MAX   = 10'd999;
    // reciprocal constants for the digit split: v/100 = (v*41)>>12 for v <= 999,
    // r/10 = (r*205)>>11 for r <= 99
    localparam logic [15:0] TENS_RECIP  = 16'd41;
    localparam int          TENS_SHIFT  = 12;
    localparam logic [14:0] UNITS_RECIP = 15'd205;
    localparam int          UNITS_SHIFT = 11;
    localparam logic [9:0]  HUNDRED     = 10'd100;
    localparam logic [6:0]  TEN         = 7'd10;

    // glyph and bar row patterns
    localparam logic [7:0] GLYPH_FULL  = 8'b11100000;
    localparam logic [7:0] GLYPH_SIDES = 8'b10100000;
    localparam logic [7:0] GLYPH_RIGHT = 8'b00100000;
    localparam logic [7:0] GLYPH_LEFT  = 8'b10000000;
    localparam logic [7:0] BAR_FULL    = 8'b11111111;
    localparam logic [7:0] BAR_TIP     = 8'b00000001;
    localparam logic [7:0] ROW_BLANK   = 8'b00000000;

    typedef logic [0:ROWS-1][7:0] plane_t;

    typedef struct packed {
        logic       operation;
        logic [9:0] value_tenths;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [7:0]       green_row;
        logic [7:0]       red_row;
        logic             last_row;
    } row_t;

    typedef struct packed {
        logic       operation;
        logic [3:0] tens;
        logic [3:0] units;
        logic [3:0] tenths;
    } digits_t;

    // 3x7 glyph in bits 7..5 of source rows 0..6, row 7 blank
    function automatic plane_t glyph_rows(input logic [3:0] d);
        plane_t p;
        unique case (d)
            4'd0: p = {GLYPH_FULL, GLYPH_SIDES, GLYPH_SIDES, GLYPH_SIDES,
                       GLYPH_SIDES, GLYPH_SIDES, GLYPH_FULL, ROW_BLANK};
            4'd1: p = {GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_RIGHT,
                       GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_RIGHT, ROW_BLANK};
            4'd2: p = {GLYPH_FULL, GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_FULL,
                       GLYPH_LEFT, GLYPH_LEFT, GLYPH_FULL, ROW_BLANK};
            4'd3: p = {GLYPH_FULL, GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_FULL,
                       GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_FULL, ROW_BLANK};
            4'd4: p = {GLYPH_SIDES, GLYPH_SIDES, GLYPH_SIDES, GLYPH_FULL,
                       GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_RIGHT, ROW_BLANK};
            4'd5: p = {GLYPH_FULL, GLYPH_LEFT, GLYPH_LEFT, GLYPH_FULL,
                       GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_FULL, ROW_BLANK};
            4'd6: p = {GLYPH_FULL, GLYPH_LEFT, GLYPH_LEFT, GLYPH_FULL,
                       GLYPH_SIDES, GLYPH_SIDES, GLYPH_FULL, ROW_BLANK};
            4'd7: p = {GLYPH_FULL, GLYPH_SIDES, GLYPH_SIDES, GLYPH_RIGHT,
                       GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_RIGHT, ROW_BLANK};
            4'd8: p = {GLYPH_FULL, GLYPH_SIDES, GLYPH_SIDES, GLYPH_FULL,
                       GLYPH_SIDES, GLYPH_SIDES, GLYPH_FULL, ROW_BLANK};
            4'd9: p = {GLYPH_FULL, GLYPH_SIDES, GLYPH_SIDES, GLYPH_FULL,
                       GLYPH_RIGHT, GLYPH_RIGHT, GLYPH_RIGHT, ROW_BLANK};
            default: p = '0;
        endcase
        return p;
    endfunction

    // bottom-row bar of t lit pixels from the left; nine also lights bit 0 above
    function automatic plane_t bar_rows(input logic [3:0] t);
        plane_t p;
        p = '0;
        if (t >= 4'd8)
        begin
            p[ROWS-1] = BAR_FULL;
        end
        else
        begin
            p[ROWS-1] = ~(BAR_FULL >> t);
        end
        if (t == 4'd9)
        begin
            p[ROWS-2] = BAR_TIP;
        end
        return p;
    endfunction

endpackage

### src/ledm_digit_split.sv
// four-stage pipeline that saturates a reading and splits it into tens, units, tenths
// depends on ledm_pkg
module ledm_digit_split (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  ledm_pkg::item_t   item,
    output logic              dig_valid,
    input  logic              dig_stall,
    output ledm_pkg::digits_t digits
);

    logic        a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic        en_a, en_b, en_c, en_d;

    logic        a_op_reg;
    logic [9:0]  a_v_reg;
    logic [15:0] a_q_reg;

    logic        b_op_reg;
    logic [3:0]  b_tens_reg;
    logic [6:0]  b_rem_reg;

    logic        c_op_reg;
    logic [3:0]  c_tens_reg;
    logic [6:0]  c_rem_reg;
    logic [14:0] c_p_reg;

    ledm_pkg::digits_t d_digits_reg;

    logic [9:0]  v_sat;
    logic [15:0] a_q_next;
    logic [3:0]  b_tens_next;
    logic [6:0]  b_rem_next;
    logic [14:0] c_p_next;
    logic [3:0]  d_units_next;
    logic [3:0]  d_tenths_next;

    // a stage moves when it is empty or the one after it moves
    assign en_d  = !d_valid_reg || !dig_stall;
    assign en_c  = !c_valid_reg || en_d;
    assign en_b  = !b_valid_reg || en_c;
    assign en_a  = !a_valid_reg || en_b;
    assign stall = !en_a;

    always_comb
    begin
        v_sat         = (item.value_tenths > ledm_pkg::VALUE_MAX) ? ledm_pkg::VALUE_MAX
                                                                  : item.value_tenths;
        a_q_next      = 16'(v_sat) * ledm_pkg::TENS_RECIP;
        b_tens_next   = a_q_reg[ledm_pkg::TENS_SHIFT +: 4];
        b_rem_next    = 7'(a_v_reg - 10'(b_tens_next) * ledm_pkg::HUNDRED);
        c_p_next      = 15'(b_rem_reg) * ledm_pkg::UNITS_RECIP;
        d_units_next  = c_p_reg[ledm_pkg::UNITS_SHIFT +: 4];
        d_tenths_next = 4'(c_rem_reg - 7'(d_units_next) * ledm_pkg::TEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (en_d)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_op_reg <= item.operation;
            a_v_reg  <= v_sat;
            a_q_reg  <= a_q_next;
        end
        if (en_b)
        begin
            b_op_reg   <= a_op_reg;
            b_tens_reg <= b_tens_next;
            b_rem_reg  <= b_rem_next;
        end
        if (en_c)
        begin
            c_op_reg   <= b_op_reg;
            c_tens_reg <= b_tens_reg;
            c_rem_reg  <= b_rem_reg;
            c_p_reg    <= c_p_next;
        end
        if (en_d)
        begin
            d_digits_reg.operation <= c_op_reg;
            d_digits_reg.tens      <= c_tens_reg;
            d_digits_reg.units     <= d_units_next;
            d_digits_reg.tenths    <= d_tenths_next;
        end
    end

    assign dig_valid = d_valid_reg;
    assign digits    = d_digits_reg;

endmodule

### src/led_matrix_two_digit_frame_top.sv
// top level of the two-digit led matrix frame builder: digit split, plane build, row output
// depends on ledm_pkg and ledm_digit_split
//
// Each accepted reading (tenths, saturated at 999, plus a temperature/humidity mode bit)
// produces eight row transactions, row 0 first, the last one flagged by last_row. Rows
// leave one per cycle while row_stall is low, so the sustained rate of readings is set
// by the row serializer that walks the registered frame. Readings enter a four-stage
// digit split pipeline and a frame register behind it, so a new reading is taken while
// the previous frame is still going out; the first row of a reading is valid once it
// has passed split stages a, b, c and d and been loaded into the frame register. Stalls
// on the row side hold the current row and back up the pipeline without dropping anything.
module led_matrix_two_digit_frame_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  ledm_pkg::item_t item,
    output logic            row_valid,
    input  logic            row_stall,
    output ledm_pkg::row_t  row
);

    logic              dig_valid;
    logic              dig_stall;
    ledm_pkg::digits_t digits;

    ledm_pkg::plane_t  green_reg, red_reg;
    ledm_pkg::plane_t  green_next, red_next;
    logic              frame_valid_reg, frame_valid_next;
    logic [ledm_pkg::ROW_W-1:0] row_cnt_reg, row_cnt_next;

    logic              last;
    logic              row_done;
    logic              frame_free;
    logic              load;

    ledm_digit_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (item_valid),
        .stall     (item_stall),
        .item      (item),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .digits    (digits)
    );

    // build both source planes and transpose them into output rows
    always_comb
    begin
        ledm_pkg::plane_t g_tens, g_units, bar, g_src, r_src;
        g_tens  = ledm_pkg::glyph_rows(digits.tens);
        g_units = ledm_pkg::glyph_rows(digits.units);
        bar     = ledm_pkg::bar_rows(digits.tenths);
        for (int k = 0; k < ledm_pkg::ROWS; k++)
        begin
            g_src[k] = g_tens[k] | (g_units[k] >> 4);
            r_src[k] = digits.operation ? (g_src[k] | bar[k]) : bar[k];
        end
        for (int j = 0; j < ledm_pkg::ROWS; j++)
        begin
            for (int i = 0; i < ledm_pkg::ROWS; i++)
            begin
                green_next[j][i] = g_src[i][j];
                red_next[j][i]   = r_src[i][j];
            end
        end
    end

    assign last       = (row_cnt_reg == ledm_pkg::ROW_W'(ledm_pkg::ROWS - 1));
    assign row_done   = row_valid && !row_stall;
    assign frame_free = !frame_valid_reg || (row_done && last);
    assign load       = dig_valid && frame_free;
    assign dig_stall  = !frame_free;

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        row_cnt_next     = row_cnt_reg;
        priority if (load)
        begin
            frame_valid_next = 1'b1;
            row_cnt_next     = '0;
        end
        else if (row_done)
        begin
            frame_valid_next = !last;
            row_cnt_next     = row_cnt_reg + 1'b1;
        end
        else
        begin
            frame_valid_next = frame_valid_reg;
            row_cnt_next     = row_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            row_cnt_reg     <= '0;
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
            row_cnt_reg     <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    assign row_valid     = frame_valid_reg;
    assign row.row_index = row_cnt_reg;
    assign row.green_row = green_reg[row_cnt_reg];
    assign row.red_row   = red_reg[row_cnt_reg];
    assign row.last_row  = last;

    // mid-frame transaction steps to the next row of the same frame
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        row_done && !last |=> frame_valid_reg
            && row_cnt_reg == ledm_pkg::ROW_W'($past(row_cnt_reg) + 1'b1))
        else $error("row counter did not advance within frame");

    // a new frame always starts at row zero
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_stall |=> frame_valid_reg && row_cnt_reg == '0)
        else $error("frame load did not restart row counter");

    // a held row keeps its frame and position
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid_reg && row_stall |=> frame_valid_reg && $stable(row_cnt_reg)
            && $stable(green_reg) && $stable(red_reg))
        else $error("frame changed under a stalled row");

    // no frame load while rows of the previous frame remain
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid_reg && !last |-> !load)
        else $error("frame overwritten before last row");

endmodule

### tb/frame_row_checker.sv
`timescale 1ns / 100ps
// row checker for the two-digit led matrix frame builder: predicts the eight row
// transactions of every accepted reading and compares them in order; depends on ledm_pkg
module frame_row_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            item_stall,
    input  ledm_pkg::item_t item,
    input  logic            row_valid,
    input  logic            row_stall,
    input  ledm_pkg::row_t  row,
    output int              mismatches,
    output int              rows_pending,
    output int              rows_checked
);

    ledm_pkg::row_t expected_rows[$];

    initial
    begin
        mismatches   = 0;
        rows_pending = 0;
        rows_checked = 0;
    end

    // source rows 0..7 of a digit glyph, row 0 in the top byte
    function automatic logic [63:0] digit_glyph(input int d);
        case (d)
            0: return 64'hE0A0A0A0A0A0E000;
            1: return 64'h2020202020202000;
            2: return 64'hE02020E08080E000;
            3: return 64'hE02020E02020E000;
            4: return 64'hA0A0A0E020202000;
            5: return 64'hE08080E02020E000;
            6: return 64'hE08080E0A0A0E000;
            7: return 64'hE0A0A02020202000;
            8: return 64'hE0A0A0E0A0A0E000;
            default: return 64'hE0A0A0E020202000;
        endcase
    endfunction

    task automatic predict_frame(input ledm_pkg::item_t it);
        int         v;
        int         tens;
        int         units;
        int         tenths;
        int         i;
        int         j;
        logic [63:0] tens_glyph;
        logic [63:0] units_glyph;
        logic [7:0]  ones;
        logic [7:0]  g;
        logic [7:0]  bar;
        logic [7:0]  green_src [0:ledm_pkg::ROWS-1];
        logic [7:0]  red_src [0:ledm_pkg::ROWS-1];
        ledm_pkg::row_t r;
        v = it.value_tenths;
        if (v > 999)
        begin
            v = 999;
        end
        tens        = v / 100;
        units       = (v / 10) % 10;
        tenths      = v % 10;
        tens_glyph  = digit_glyph(tens);
        units_glyph = digit_glyph(units);
        ones        = 8'hFF;
        for (i = 0; i < ledm_pkg::ROWS; i++)
        begin
            g   = tens_glyph[63 - 8 * i -: 8] | (units_glyph[63 - 8 * i -: 8] >> 4);
            bar = 8'h00;
            if (i == ledm_pkg::ROWS - 1)
            begin
                bar = (tenths >= 8) ? ones : ~(ones >> tenths);
            end
            // tenths nine also lights the tip pixel one row up
            if (i == ledm_pkg::ROWS - 2 && tenths == 9)
            begin
                bar = 8'h01;
            end
            green_src[i] = g;
            red_src[i]   = it.operation ? (g | bar) : bar;
        end
        // out row j bit i = source row i bit j
        for (j = 0; j < ledm_pkg::ROWS; j++)
        begin
            r.row_index = ledm_pkg::ROW_W'(j);
            for (i = 0; i < ledm_pkg::ROWS; i++)
            begin
                r.green_row[i] = green_src[i][j];
                r.red_row[i]   = red_src[i][j];
            end
            r.last_row = (j == ledm_pkg::ROWS - 1);
            expected_rows.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
        begin
            $display("%0t checker: %s", $time, what);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        ledm_pkg::row_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                predict_frame(item);
            end
            if (row_valid && !row_stall)
            begin
                if (expected_rows.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected row transaction, row_index %0d",
                                              row.row_index));
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (row.row_index !== want.row_index)
                        report_mismatch($sformatf("row_index got %0d want %0d",
                                                  row.row_index, want.row_index));
                    if (row.green_row !== want.green_row)
                        report_mismatch($sformatf("row %0d green_row got %h want %h",
                                                  want.row_index, row.green_row,
                                                  want.green_row));
                    if (row.red_row !== want.red_row)
                        report_mismatch($sformatf("row %0d red_row got %h want %h",
                                                  want.row_index, row.red_row,
                                                  want.red_row));
                    if (row.last_row !== want.last_row)
                        report_mismatch($sformatf("row %0d last_row got %b want %b",
                                                  want.row_index, row.last_row,
                                                  want.last_row));
                    rows_checked++;
                end
            end
            rows_pending = expected_rows.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// top of the frame builder testbench: clock, reset, reading stimulus, row-side stalls
// and the verdict; depends on ledm_pkg, frame_row_checker and led_matrix_two_digit_frame_top
module tb;

    localparam int LIMIT = 300000;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  item_valid;
    logic  item_stall;
    ledm_pkg::item_t item;
    logic  row_valid;
    logic  row_stall;
    ledm_pkg::row_t  row;

    int mismatches;
    int rows_pending;
    int rows_checked;
    int cycles = 0;
    int readings = 0;
    int humid_readings = 0;
    int saturated = 0;
    int stall_left = 0;
    bit idling_on = 1'b1;

    // readings for the directed part: zero, tenths nine, above range, all bits set, mixed digits
    int directed_values [0:11] = '{0, 9, 90, 123, 456, 789, 999, 1000, 1023, 512, 618, 265};

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    led_matrix_two_digit_frame_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .row_valid  (row_valid),
        .row_stall  (row_stall),
        .row        (row)
    );

    frame_row_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .row_valid    (row_valid),
        .row_stall    (row_stall),
        .row          (row),
        .mismatches   (mismatches),
        .rows_pending (rows_pending),
        .rows_checked (rows_checked)
    );

    // mostly short, now and then long
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(9, 30);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            row_stall <= 1'b1;
        end
        else if (idling_on && rst_n && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_len() - 1;
            row_stall <= 1'b1;
        end
        else
        begin
            row_stall <= 1'b0;
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_reading(input bit op, input int v);
        ledm_pkg::item_t next;
        int    gap;
        gap = (idling_on && $urandom_range(0, 1) == 1) ? pick_len() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        next.operation    = op;
        next.value_tenths = v[9:0];
        item       <= next;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        readings++;
        if (op)
            humid_readings++;
        if (v > 999)
            saturated++;
        @(negedge clk);
    endtask

    initial
    begin
        wait (cycles >= LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int k;
        bit op;
        int v;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        row_stall  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < 24; k++)
        begin
            send_reading(k[0], directed_values[k / 2]);
        end

        for (k = 0; k < 156; k++)
        begin
            // some blocks run with no gaps or stalls at all
            if (k % 30 == 0)
                idling_on = ($urandom_range(0, 3) != 0);
            op = 1'($urandom_range(0, 1));
            v  = ($urandom_range(0, 9) == 0) ? $urandom_range(1000, 1023)
                                             : $urandom_range(0, 999);
            send_reading(op, v);
        end
        item_valid <= 1'b0;

        while (rows_pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("tb: %0d readings sent (%0d humidity mode, %0d above range)",
                 readings, humid_readings, saturated);
        $display("tb: %0d row transactions checked in %0d cycles, %0d mismatches",
                 rows_checked, cycles, mismatches);
        if (mismatches == 0 && rows_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
